>>> design/rgbmorph_pkg.sv
// ----------------------------------------------------------------------------
// rgbmorph_pkg
// Shared types and constants for the RGB erosion and dilation block.
// ----------------------------------------------------------------------------
package rgbmorph_pkg;

  // Field and register widths fixed by the interface.
  localparam int unsigned POS_W     = 8;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned DIM_W     = 9;
  localparam int unsigned KER_W     = 4;
  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 32;

  // Signed width for window coordinates before folding. It covers a
  // position plus or minus half a window and the mirror about an edge
  // of up to 511 pixels.
  localparam int unsigned CW        = 12;
  // Signed width of a window offset.
  localparam int unsigned OFS_W     = KER_W + 1;
  // Width of squared distances and the disc threshold.
  localparam int unsigned DIST_W    = 8;

  localparam logic signed [CW-1:0] ONE_S = 1;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 9'd256;
  localparam logic [KER_W-1:0] KERNEL_RST = 4'd3;

  // Operation codes.
  localparam logic OP_ERODE  = 1'b0;
  localparam logic OP_DILATE = 1'b1;

  // Request kinds carried in tuser.
  localparam logic REQ_STORE   = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  // Accumulator start values.
  localparam logic [CH_W-1:0] CH_MAX = 8'd255;
  localparam logic [CH_W-1:0] CH_MIN = 8'd0;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_KERNEL = 2'd2,
    REG_OP     = 2'd3
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WRITE = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  // One stored pixel.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  // Mirror a coordinate once about the image edges, then clamp it.
  function automatic logic signed [CW-1:0] fold_coord(input logic signed [CW-1:0] p,
                                                      input logic signed [CW-1:0] n);
    logic signed [CW-1:0] q;
    q = p;
    if (q < 0) begin
      q = -q;
    end
    if (q >= n) begin
      q = ((n - ONE_S) <<< 1) - q;
    end
    if (q < 0) begin
      q = '0;
    end
    if (q > n - ONE_S) begin
      q = n - ONE_S;
    end
    return q;
  endfunction

endpackage

>>> design/rgb_morphological_erode_dilate.sv
// ----------------------------------------------------------------------------
// rgb_morphological_erode_dilate
// RGB erosion and dilation over a disc-shaped window on a stored image.
// ----------------------------------------------------------------------------
// The image lives in one single-port synchronous memory of MAX_WIDTH x
// MAX_HEIGHT pixels. A store transfer (tuser low) writes one pixel. A
// compute transfer (tuser high) walks the k x k window one offset per
// cycle through the memory port, where k is the kernel size; the single
// memory read port sets this pace. Window offsets outside the disc still
// take their scan step but are not read. The result sits in an output
// register, so the next item is taken while a result waits to be
// collected. Pixels never written read back undefined.
// ----------------------------------------------------------------------------
module rgb_morphological_erode_dilate
  import rgbmorph_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_KERNEL = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input stream.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: pos_x[7:0], pos_y[15:8], in_red[23:16], in_green[31:24],
  // in_blue[39:32]
  input  logic [39:0]       s_axis_tdata,
  // tuser: req_type[0]
  input  logic              s_axis_tuser,
  // Result stream.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // tdata: out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic [23:0]       m_axis_tdata,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);

  // Configuration registers.
  logic [DIM_W-1:0] cfg_width_q, cfg_height_q;
  logic [KER_W-1:0] cfg_kernel_q;
  logic             cfg_op_q;
  cfg_reg_e         reg_sel;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WIDTH_RST;
      cfg_height_q <= HEIGHT_RST;
      cfg_kernel_q <= KERNEL_RST;
      cfg_op_q     <= OP_ERODE;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_WIDTH:  cfg_width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg_height_q <= pwdata[DIM_W-1:0];
        REG_KERNEL: cfg_kernel_q <= pwdata[KER_W-1:0];
        REG_OP:     cfg_op_q     <= pwdata[0];
        default:    cfg_op_q     <= cfg_op_q;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = APB_DW'(cfg_width_q);
      REG_HEIGHT: prdata = APB_DW'(cfg_height_q);
      REG_KERNEL: prdata = APB_DW'(cfg_kernel_q);
      REG_OP:     prdata = APB_DW'(cfg_op_q);
      default:    prdata = '0;
    endcase
  end

  // Effective image size and window geometry.
  logic signed [CW-1:0]  eff_w, eff_h;
  logic [KER_W-1:0]      k_eff, k_half, k_last;
  logic [DIST_W-1:0]     thr;

  always_comb begin
    if (cfg_width_q == '0) begin
      eff_w = ONE_S;
    end else if (int'(cfg_width_q) > MAX_WIDTH) begin
      eff_w = signed'(CW'(MAX_WIDTH));
    end else begin
      eff_w = signed'(CW'(cfg_width_q));
    end
    if (cfg_height_q == '0) begin
      eff_h = ONE_S;
    end else if (int'(cfg_height_q) > MAX_HEIGHT) begin
      eff_h = signed'(CW'(MAX_HEIGHT));
    end else begin
      eff_h = signed'(CW'(cfg_height_q));
    end
    if (int'(cfg_kernel_q) > MAX_KERNEL) begin
      k_eff = KER_W'(MAX_KERNEL);
    end else begin
      k_eff = cfg_kernel_q;
    end
    k_half = k_eff >> 1;
    k_last = k_eff - KER_W'(1);
    thr    = DIST_W'((DIST_W'(k_half) * DIST_W'(k_eff)) >> 1);
  end

  // Sequencer and item registers.
  state_e             state_q, state_d;
  logic [KER_W-1:0]   m_q, n_q;
  logic               drain_q;
  logic [POS_W-1:0]   cx_q, cy_q;
  logic [XW-1:0]      px_q;
  logic [YW-1:0]      py_q;
  pixel_t             wpix_q;
  logic               wr_ok_q;
  logic               rd_v1_q, rd_v2_q;
  pixel_t             rdata_q;
  pixel_t             acc_q;
  logic               out_valid_q;
  pixel_t             out_q;

  logic               in_xfer, out_free, scan_last;
  logic [POS_W-1:0]   in_x, in_y;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign in_x          = s_axis_tdata[7:0];
  assign in_y          = s_axis_tdata[15:8];
  assign out_free      = !out_valid_q || m_axis_tready;
  assign scan_last     = (k_eff == '0) || ((m_q == k_last) && (n_q == k_last));

  // Window offset for the current scan step and its disc test.
  logic signed [OFS_W-1:0]  dx, dy;
  logic signed [DIST_W-1:0] dxw, dyw;
  logic [DIST_W-1:0]        dist_sq;
  logic                     in_disc;
  logic signed [CW-1:0]     fx, fy;

  always_comb begin
    dx      = signed'(OFS_W'(m_q)) - signed'(OFS_W'(k_half));
    dy      = signed'(OFS_W'(n_q)) - signed'(OFS_W'(k_half));
    dxw     = DIST_W'(dx);
    dyw     = DIST_W'(dy);
    dist_sq = DIST_W'(dxw * dxw) + DIST_W'(dyw * dyw);
    in_disc = (k_eff != '0) && (dist_sq <= thr);
    fx      = fold_coord(signed'(CW'(cx_q)) + CW'(dx), eff_w);
    fy      = fold_coord(signed'(CW'(cy_q)) + CW'(dy), eff_h);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = (s_axis_tuser == REQ_COMPUTE) ? ST_SCAN : ST_WRITE;
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      m_q         <= '0;
      n_q         <= '0;
      drain_q     <= 1'b0;
      wr_ok_q     <= 1'b0;
      rd_v1_q     <= 1'b0;
      rd_v2_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v1_q <= (state_q == ST_SCAN) && in_disc;
      rd_v2_q <= rd_v1_q;
      drain_q <= (state_q == ST_DRAIN) ? !drain_q : 1'b0;
      if (in_xfer) begin
        m_q     <= '0;
        n_q     <= '0;
        wr_ok_q <= (s_axis_tuser == REQ_STORE) &&
                   (int'(in_x) < MAX_WIDTH) && (int'(in_y) < MAX_HEIGHT);
      end else if (state_q == ST_SCAN) begin
        if (n_q == k_last) begin
          n_q <= '0;
          m_q <= m_q + KER_W'(1);
        end else begin
          n_q <= n_q + KER_W'(1);
        end
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload, folded coordinates and accumulator.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cx_q         <= in_x;
      cy_q         <= in_y;
      px_q         <= XW'(in_x);
      py_q         <= YW'(in_y);
      wpix_q.red   <= s_axis_tdata[23:16];
      wpix_q.green <= s_axis_tdata[31:24];
      wpix_q.blue  <= s_axis_tdata[39:32];
      acc_q        <= (cfg_op_q == OP_DILATE) ? {3{CH_MIN}} : {3{CH_MAX}};
    end else begin
      if (state_q == ST_SCAN) begin
        px_q <= XW'(unsigned'(fx));
        py_q <= YW'(unsigned'(fy));
      end
      if (rd_v2_q) begin
        if (cfg_op_q == OP_DILATE) begin
          if (rdata_q.red   > acc_q.red)   acc_q.red   <= rdata_q.red;
          if (rdata_q.green > acc_q.green) acc_q.green <= rdata_q.green;
          if (rdata_q.blue  > acc_q.blue)  acc_q.blue  <= rdata_q.blue;
        end else begin
          if (rdata_q.red   < acc_q.red)   acc_q.red   <= rdata_q.red;
          if (rdata_q.green < acc_q.green) acc_q.green <= rdata_q.green;
          if (rdata_q.blue  < acc_q.blue)  acc_q.blue  <= rdata_q.blue;
        end
      end
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_q <= acc_q;
    end
  end

  // Image memory: one port, shared by stores and window reads.
  pixel_t        mem [DEPTH];
  logic [AW-1:0] mem_addr;
  logic          mem_we;

  assign mem_addr = AW'(AW'(py_q) * AW'(MAX_WIDTH)) + AW'(px_q);
  assign mem_we   = (state_q == ST_WRITE) && wr_ok_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= wpix_q;
    end
    rdata_q <= mem[mem_addr];
  end

  // Result stream.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.blue, out_q.green, out_q.red};

endmodule

>>> tb/rgb_morphological_erode_dilate_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_morphological_erode_dilate_tb
// Self-checking bench for the RGB erosion and dilation block. A short table
// of store, compute and register rows comes first, then random phases, each
// with its own image size, window size and operation. Each compute result is
// either given in its table row or predicted from a local copy of the pixel
// store; a random compute first stores each never-written pixel its window
// reads. Results are compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module rgb_morphological_erode_dilate_tb
  import rgbmorph_pkg::*;
();

  localparam int unsigned IMG_SIDE      = 256;
  localparam int unsigned RANDOM_ITEMS  = 850;
  // Transfers per random phase, so that every phase gets its turn.
  localparam int unsigned PHASE_ITEMS   = 100;
  // Longest compute is a full 15 x 15 walk plus its overhead.
  localparam int unsigned SETTLE_CYCLES = 240;

  typedef struct packed {
    logic             req;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] x;
    pixel_t           px;
  } morph_req_t;

  typedef enum logic [1:0] {
    ROW_STORE,
    ROW_COMPUTE,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    cfg_reg_e         reg_idx;
    logic [8:0]       a;
    logic [POS_W-1:0] b;
    pixel_t           rgb;
    logic             typed;
    pixel_t           want;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b1;
  logic [23:0]       m_axis_tdata;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Local copy of the block's state and configuration.
  pixel_t            image_mem [0:IMG_SIDE*IMG_SIDE-1];
  bit                pix_written [0:IMG_SIDE*IMG_SIDE-1];
  logic [DIM_W-1:0]  cfg_width  = WIDTH_RST;
  logic [DIM_W-1:0]  cfg_height = HEIGHT_RST;
  logic [KER_W-1:0]  cfg_kernel = KERNEL_RST;
  logic              cfg_op     = OP_ERODE;
  int                tap_addrs [$];
  pixel_t            pending_pixels [$];

  int                err_count      = 0;
  int                transfers_in   = 0;
  int                stores_in      = 0;
  int                computes_in    = 0;
  int                pixels_checked = 0;
  int                settings_run   = 0;
  int                burst_left     = 0;
  int                stall_tick     = 0;
  int                stall_mode     = 0;
  dir_row_t          dir_rows [27];

  rgb_morphological_erode_dilate dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Image dimension as the block uses it: zero acts as one, and anything
  // above the store saturates.
  function automatic int eff_dim(input logic [DIM_W-1:0] v);
    if (v == 0) begin
      return 1;
    end
    if (v > IMG_SIDE) begin
      return IMG_SIDE;
    end
    return int'(v);
  endfunction

  // Mirror once about the nearer edge, then clamp into the image.
  function automatic int mirror_clamp(input int p, input int n);
    if (p < 0) begin
      p = -p;
    end
    if (p >= n) begin
      p = 2 * (n - 1) - p;
    end
    if (p < 0) begin
      p = 0;
    end
    if (p > n - 1) begin
      p = n - 1;
    end
    return p;
  endfunction

  // Collect the store addresses read for a window centered at (cx,cy).
  // Only offsets inside the disc threshold are read.
  function automatic void window_taps(input int cx, input int cy);
    int w, h, k, c, thr, dx, dy;
    w   = eff_dim(cfg_width);
    h   = eff_dim(cfg_height);
    k   = int'(cfg_kernel);
    c   = k / 2;
    thr = (c * k) / 2;
    tap_addrs.delete();
    for (int m = 0; m < k; m++) begin
      for (int n = 0; n < k; n++) begin
        dx = m - c;
        dy = n - c;
        if (dx * dx + dy * dy <= thr) begin
          tap_addrs.push_back(mirror_clamp(cy + dy, h) * IMG_SIDE + mirror_clamp(cx + dx, w));
        end
      end
    end
  endfunction

  function automatic logic [CH_W-1:0] rank_pick(input logic [CH_W-1:0] acc,
                                                input logic [CH_W-1:0] v);
    if (cfg_op == OP_DILATE) begin
      return (v > acc) ? v : acc;
    end
    return (v < acc) ? v : acc;
  endfunction

  // Per-channel minimum or maximum over the disc window.
  function automatic pixel_t morph_pixel(input int cx, input int cy);
    pixel_t acc, px;
    acc = (cfg_op == OP_DILATE) ? {3{CH_MIN}} : {3{CH_MAX}};
    window_taps(cx, cy);
    foreach (tap_addrs[i]) begin
      px        = image_mem[tap_addrs[i]];
      acc.red   = rank_pick(acc.red, px.red);
      acc.green = rank_pick(acc.green, px.green);
      acc.blue  = rank_pick(acc.blue, px.blue);
    end
    return acc;
  endfunction

  // Update the local store or queue a prediction for one accepted transfer.
  function automatic void absorb_request(input morph_req_t it, input bit typed,
                                         input pixel_t want);
    transfers_in++;
    if (it.req == REQ_STORE) begin
      stores_in++;
      image_mem[{it.y, it.x}]   = it.px;
      pix_written[{it.y, it.x}] = 1'b1;
    end else begin
      computes_in++;
      pending_pixels.push_back(typed ? want : morph_pixel(int'(it.x), int'(it.y)));
    end
  endfunction

  function automatic int rand_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return 0;
    end
    if (r < 75) begin
      return $urandom_range(1, 20);
    end
    if (r < 90) begin
      return $urandom_range(21, 256);
    end
    return $urandom_range(257, 511);
  endfunction

  // Mostly near an anchor inside the image, with edges and far-off points.
  function automatic int pick_coord(input int eff, input int anchor);
    int r, p;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return 0;
    end
    if (r < 16) begin
      return eff - 1;
    end
    if (r < 21) begin
      return 255;
    end
    if (r < 28) begin
      return $urandom_range(0, 255);
    end
    if (eff <= 32) begin
      return $urandom_range(0, eff - 1);
    end
    p = anchor + $urandom_range(0, 20) - 10;
    return (p < 0) ? 0 : ((p > eff - 1) ? eff - 1 : p);
  endfunction

  function automatic void check_channel(input string name, input logic [CH_W-1:0] want,
                                        input logic [CH_W-1:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
    end
  endfunction

  // Drive one transfer on the input stream. The sender runs in bursts, with
  // a random gap before each new burst.
  task automatic send_item(input morph_req_t it, input bit typed, input pixel_t want);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.req;
    s_axis_tdata  <= {it.px.blue, it.px.green, it.px.red, it.y, it.x};
    do @(posedge clk_i); while (!s_axis_tready);
    absorb_request(it, typed, want);
  endtask

  task automatic store_at(input int x, input int y);
    morph_req_t it;
    it.req = REQ_STORE;
    it.x   = POS_W'(x);
    it.y   = POS_W'(y);
    it.px  = 24'($urandom());
    send_item(it, 1'b0, '0);
  endtask

  // Store every pixel the window will read that was never written, then
  // issue the compute itself.
  task automatic compute_at(input int x, input int y);
    morph_req_t it;
    int         need [$];
    window_taps(x, y);
    need = tap_addrs;
    foreach (need[i]) begin
      if (!pix_written[need[i]]) begin
        store_at(need[i] % IMG_SIDE, need[i] / IMG_SIDE);
      end
    end
    it.req = REQ_COMPUTE;
    it.x   = POS_W'(x);
    it.y   = POS_W'(y);
    it.px  = 24'($urandom());
    send_item(it, 1'b0, '0);
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic drain_results(input bit settle);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    if (settle) begin
      repeat (SETTLE_CYCLES) @(posedge clk_i);
    end
  endtask

  // Write one register, then read it back.
  task automatic set_reg(input cfg_reg_e idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] mask;
    case (idx)
      REG_WIDTH:  mask = 32'h1FF;
      REG_HEIGHT: mask = 32'h1FF;
      REG_KERNEL: mask = 32'hF;
      default:    mask = 32'h1;
    endcase
    for (int rd = 0; rd < 2; rd++) begin
      @(negedge clk_i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (rd == 0);
      paddr   <= {idx, 2'b00};
      pwdata  <= value & mask;
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (rd == 1 && prdata !== (value & mask)) begin
        err_count++;
        $display("%0t: register %s readback, expected %08h, actual %08h",
                 $time, idx.name(), value & mask, prdata);
      end
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WIDTH:  cfg_width  = value[DIM_W-1:0];
      REG_HEIGHT: cfg_height = value[DIM_W-1:0];
      REG_KERNEL: cfg_kernel = value[KER_W-1:0];
      default:    cfg_op     = value[0];
    endcase
  endtask

  // Result stream stalls: stall_mode picks between always ready, coin flips,
  // a fixed duty cycle and long stalls, and is redrawn as stall_tick advances.
  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 256 == 0) begin
      stall_mode <= $urandom_range(0, 3);
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (stall_tick % 5) < 2;
      default: m_axis_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    pixel_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.red   = m_axis_tdata[7:0];
      got.green = m_axis_tdata[15:8];
      got.blue  = m_axis_tdata[23:16];
      pixels_checked++;
      if (pending_pixels.size() == 0) begin
        err_count++;
        $display("%0t: result %02h %02h %02h arrived with nothing expected",
                 $time, got.red, got.green, got.blue);
      end else begin
        want = pending_pixels.pop_front();
        check_channel("out_red", want.red, got.red);
        check_channel("out_green", want.green, got.green);
        check_channel("out_blue", want.blue, got.blue);
      end
    end
  end

  initial begin
    #40000000;
    $display("rgb_morphological_erode_dilate_tb failed");
    $finish;
  end

  initial begin : stimulus
    morph_req_t it;
    int         base_items, phase_base, n_items, ax, ay, w, h, k, ew, eh;
    logic       op;

    s_axis_tvalid = 1'b0;
    s_axis_tuser  = REQ_STORE;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst_ni        = 1'b0;

    // Directed rows: corners, mirror at both edges, an empty window in both
    // modes, a single-tap window, a one-pixel image, oversized dimensions
    // and an even (off-center) window.
    dir_rows[0]  = '{ROW_STORE,   REG_WIDTH,  9'd0,   8'd0,   24'hFFFFFF, 1'b0, 24'h0};
    dir_rows[1]  = '{ROW_STORE,   REG_WIDTH,  9'd1,   8'd0,   24'hFFFFFF, 1'b0, 24'h0};
    dir_rows[2]  = '{ROW_STORE,   REG_WIDTH,  9'd0,   8'd1,   24'hFFFFFF, 1'b0, 24'h0};
    dir_rows[3]  = '{ROW_COMPUTE, REG_WIDTH,  9'd0,   8'd0,   24'h000000, 1'b1, 24'hFFFFFF};
    dir_rows[4]  = '{ROW_STORE,   REG_WIDTH,  9'd1,   8'd0,   24'h000000, 1'b0, 24'h0};
    dir_rows[5]  = '{ROW_COMPUTE, REG_WIDTH,  9'd0,   8'd0,   24'hFFFFFF, 1'b1, 24'h000000};
    dir_rows[6]  = '{ROW_STORE,   REG_WIDTH,  9'd255, 8'd255, 24'hA55A0F, 1'b0, 24'h0};
    dir_rows[7]  = '{ROW_STORE,   REG_WIDTH,  9'd254, 8'd255, 24'hFFFFFF, 1'b0, 24'h0};
    dir_rows[8]  = '{ROW_STORE,   REG_WIDTH,  9'd255, 8'd254, 24'hFFFFFF, 1'b0, 24'h0};
    dir_rows[9]  = '{ROW_COMPUTE, REG_WIDTH,  9'd255, 8'd255, 24'h5AA5F0, 1'b1, 24'hA55A0F};
    dir_rows[10] = '{ROW_REG,     REG_KERNEL, 9'd0,   8'd0,   24'h0,      1'b0, 24'h0};
    dir_rows[11] = '{ROW_COMPUTE, REG_WIDTH,  9'd200, 8'd100, 24'h0,      1'b1, 24'hFFFFFF};
    dir_rows[12] = '{ROW_REG,     REG_OP,     9'd1,   8'd0,   24'h0,      1'b0, 24'h0};
    dir_rows[13] = '{ROW_COMPUTE, REG_WIDTH,  9'd7,   8'd7,   24'hFFFFFF, 1'b1, 24'h000000};
    dir_rows[14] = '{ROW_REG,     REG_KERNEL, 9'd1,   8'd0,   24'h0,      1'b0, 24'h0};
    dir_rows[15] = '{ROW_COMPUTE, REG_WIDTH,  9'd255, 8'd255, 24'h0,      1'b1, 24'hA55A0F};
    dir_rows[16] = '{ROW_REG,     REG_WIDTH,  9'd0,   8'd0,   24'h0,      1'b0, 24'h0};
    dir_rows[17] = '{ROW_REG,     REG_HEIGHT, 9'd0,   8'd0,   24'h0,      1'b0, 24'h0};
    dir_rows[18] = '{ROW_REG,     REG_KERNEL, 9'd15,  8'd0,   24'h0,      1'b0, 24'h0};
    dir_rows[19] = '{ROW_COMPUTE, REG_WIDTH,  9'd255, 8'd0,   24'h0,      1'b1, 24'hFFFFFF};
    dir_rows[20] = '{ROW_COMPUTE, REG_WIDTH,  9'd0,   8'd255, 24'h0,      1'b1, 24'hFFFFFF};
    dir_rows[21] = '{ROW_REG,     REG_WIDTH,  9'd511, 8'd0,   24'h0,      1'b0, 24'h0};
    dir_rows[22] = '{ROW_REG,     REG_HEIGHT, 9'd511, 8'd0,   24'h0,      1'b0, 24'h0};
    dir_rows[23] = '{ROW_REG,     REG_KERNEL, 9'd2,   8'd0,   24'h0,      1'b0, 24'h0};
    dir_rows[24] = '{ROW_REG,     REG_OP,     9'd0,   8'd0,   24'h0,      1'b0, 24'h0};
    dir_rows[25] = '{ROW_COMPUTE, REG_WIDTH,  9'd0,   8'd0,   24'h0,      1'b0, 24'h0};
    dir_rows[26] = '{ROW_COMPUTE, REG_WIDTH,  9'd255, 8'd255, 24'h0,      1'b0, 24'h0};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table under the reset configuration and its edits.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        drain_results(1'b1);
        set_reg(dir_rows[i].reg_idx, 32'(dir_rows[i].a));
        settings_run++;
      end else begin
        it.req = (dir_rows[i].kind == ROW_COMPUTE) ? REQ_COMPUTE : REQ_STORE;
        it.x   = dir_rows[i].a[POS_W-1:0];
        it.y   = dir_rows[i].b;
        it.px  = dir_rows[i].rgb;
        send_item(it, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases: the first few use extreme settings, the rest are drawn.
    base_items = transfers_in;
    for (int phase = 0; transfers_in - base_items < RANDOM_ITEMS; phase++) begin
      case (phase)
        0:       begin w = 2;   h = 3;   k = 15; op = OP_DILATE; end
        1:       begin w = 1;   h = 1;   k = 1;  op = OP_ERODE;  end
        2:       begin w = 256; h = 256; k = 15; op = OP_ERODE;  end
        3:       begin w = 300; h = 5;   k = 4;  op = OP_DILATE; end
        4:       begin w = 7;   h = 511; k = 14; op = OP_ERODE;  end
        5:       begin w = 16;  h = 16;  k = 0;  op = OP_DILATE; end
        default: begin
          w  = rand_dim();
          h  = rand_dim();
          k  = $urandom_range(0, 15);
          op = 1'($urandom_range(0, 1));
        end
      endcase
      drain_results(1'b1);
      set_reg(REG_WIDTH, 32'(w));
      set_reg(REG_HEIGHT, 32'(h));
      set_reg(REG_KERNEL, 32'(k));
      set_reg(REG_OP, 32'(op));
      settings_run++;
      ew         = eff_dim(cfg_width);
      eh         = eff_dim(cfg_height);
      ax         = $urandom_range(0, ew - 1);
      ay         = $urandom_range(0, eh - 1);
      n_items    = $urandom_range(30, 90);
      phase_base = transfers_in;
      repeat (n_items) begin
        // Large windows pull in many stores; keep each phase and the whole
        // random part within their transfer budgets.
        if ((transfers_in - phase_base >= PHASE_ITEMS) ||
            (transfers_in - base_items >= RANDOM_ITEMS)) begin
          break;
        end
        if ($urandom_range(0, 99) < 45) begin
          compute_at(pick_coord(ew, ax), pick_coord(eh, ay));
        end else begin
          store_at(pick_coord(ew, ax), pick_coord(eh, ay));
        end
        // Now and then let the block run dry before sending more.
        if ($urandom_range(0, 49) == 0) begin
          drain_results(1'b0);
        end
      end
    end

    drain_results(1'b1);
    $display("Sent %0d transfers (%0d stores, %0d computes) over %0d register settings.",
             transfers_in, stores_in, computes_in, settings_run);
    $display("Checked %0d result pixels; %0d errors.", pixels_checked, err_count);
    if (err_count == 0) begin
      $display("rgb_morphological_erode_dilate_tb passed");
    end else begin
      $display("rgb_morphological_erode_dilate_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/rgbmorph_pkg.sv
design/rgb_morphological_erode_dilate.sv
tb/rgb_morphological_erode_dilate_tb.sv
